/* src/bal_pkg.sv */
// Shared types, widths, constants and microcode encodings of the balance controller.
package bal_pkg;

  // Field and datapath widths.
  localparam int GAIN_W     = 26;
  localparam int DATA_W     = 16;
  localparam int DIST_W     = 10;
  localparam int DIFF_W     = 17;
  localparam int ERR_W      = 18;
  localparam int FILT_W     = 19;
  localparam int INTEG_W    = 15;
  localparam int TSPD_W     = 5;
  localparam int TURN_SPD_W = 8;
  localparam int OPB_W      = 30;
  localparam int PROD_W     = 56;
  localparam int ACC_W      = 48;
  localparam int UP_W       = 28;
  localparam int TURN_W     = 28;
  localparam int OUT_W      = 17;
  localparam int LIMIT_W    = 16;
  localparam int STEP_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  // Filter coefficients, 0.3 and 0.7 in Q.16.
  localparam int FILT_NEW    = 19661;
  localparam int FILT_OLD    = 45875;
  localparam int INTEG_MAX   = 10000;
  localparam int NEAR_CM     = 30;
  localparam int TURN_MAX    = 60;
  localparam int TURN_STEP   = 20;
  localparam int AVOID_SPEED = 5;
  localparam int SPEED_MAX   = 10;
  localparam int DAMP_RESET  = 52429;

  // Configuration reset values.
  localparam int RST_ANGLE_KP      = -18350080;
  localparam int RST_ANGLE_KD      = -78643;
  localparam int RST_SPEED_KP      = 104858;
  localparam int RST_SPEED_KI      = 524;
  localparam int RST_TURN_KP       = 1966080;
  localparam int RST_TURN_KD_IDLE  = 39322;
  localparam int RST_BALANCE_ANGLE = 0;
  localparam int RST_DRIVE_LIMIT   = 7000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_KP      = 3'd0,
    REG_ANGLE_KD      = 3'd1,
    REG_SPEED_KP      = 3'd2,
    REG_SPEED_KI      = 3'd3,
    REG_TURN_KP       = 3'd4,
    REG_TURN_KD_IDLE  = 3'd5,
    REG_BALANCE_ANGLE = 3'd6,
    REG_DRIVE_LIMIT   = 3'd7
  } cfg_reg_e;

  // Multiplier operand A (gain side).
  typedef enum logic [2:0] {
    A_AKP, A_AKD, A_SKP, A_SKI, A_TKP, A_DAMP, A_FNEW, A_FOLD
  } a_sel_e;

  // Multiplier operand B (signal side).
  typedef enum logic [2:0] {
    B_DIFF, B_PRATE, B_YAW, B_ERR, B_FILT, B_INTEG, B_TURNSPD, B_ACC
  } b_sel_e;

  // Truncating shift applied to the registered product.
  typedef enum logic [1:0] {
    SH_0, SH_16, SH_23
  } shift_e;

  // Accumulator operation.
  typedef enum logic [2:0] {
    ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_LDUP
  } acc_op_e;

  // Write-back target.
  typedef enum logic [2:0] {
    WB_NONE, WB_FILT, WB_INTEG, WB_UP, WB_TURN, WB_OUT
  } wb_e;

  // Sequencer next-step control.
  typedef enum logic [1:0] {
    J_NEXT, J_WAIT_IN, J_END
  } jump_e;

  typedef struct packed {
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    shift_e  shift;
    acc_op_e acc_op;
    wb_e     wb;
    jump_e   jump;
  } uword_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    uword_t uw;
    logic   take;
    logic   out_load;
  } bal_ctl_t;

endpackage

/* src/bal_urom.sv */
// Microcode ROM: one control word per step of the control-tick program.
module bal_urom import bal_pkg::*; (
  input  logic [STEP_W-1:0] step,
  output uword_t            uw
);

  // A product lands in prod, is truncated into tq, then accumulated.
  always_comb begin
    unique case (step)
      4'd0:  uw = '{A_AKP,  B_DIFF,    SH_0,  ACC_NOP,  WB_NONE,  J_WAIT_IN};
      // Filter terms: 0.3 * err and 0.7 * previous filter value.
      4'd1:  uw = '{A_FNEW, B_ERR,     SH_0,  ACC_NOP,  WB_NONE,  J_NEXT};
      4'd2:  uw = '{A_FOLD, B_FILT,    SH_0,  ACC_NOP,  WB_NONE,  J_NEXT};
      // Upright terms while the filter sum builds up.
      4'd3:  uw = '{A_AKP,  B_DIFF,    SH_0,  ACC_LOAD, WB_NONE,  J_NEXT};
      4'd4:  uw = '{A_AKD,  B_PRATE,   SH_23, ACC_ADD,  WB_NONE,  J_NEXT};
      4'd5:  uw = '{A_DAMP, B_YAW,     SH_16, ACC_LOAD, WB_FILT,  J_NEXT};
      4'd6:  uw = '{A_TKP,  B_TURNSPD, SH_16, ACC_ADD,  WB_INTEG, J_NEXT};
      // Speed terms, upright saved, turn built.
      4'd7:  uw = '{A_SKP,  B_FILT,    SH_16, ACC_LOAD, WB_UP,    J_NEXT};
      4'd8:  uw = '{A_SKI,  B_INTEG,   SH_16, ACC_ADD,  WB_NONE,  J_NEXT};
      4'd9:  uw = '{A_SKI,  B_INTEG,   SH_16, ACC_LOAD, WB_TURN,  J_NEXT};
      4'd10: uw = '{A_SKI,  B_INTEG,   SH_16, ACC_ADD,  WB_NONE,  J_NEXT};
      // Speed correction through the upright gain.
      4'd11: uw = '{A_AKP,  B_ACC,     SH_16, ACC_LDUP, WB_NONE,  J_NEXT};
      4'd12: uw = '{A_AKP,  B_ACC,     SH_16, ACC_NOP,  WB_NONE,  J_NEXT};
      4'd13: uw = '{A_AKP,  B_ACC,     SH_16, ACC_SUB,  WB_NONE,  J_NEXT};
      // Mix, clamp and load the output register.
      4'd14: uw = '{A_AKP,  B_ACC,     SH_16, ACC_NOP,  WB_OUT,   J_END};
      default: uw = '{A_AKP, B_DIFF,   SH_0,  ACC_NOP,  WB_NONE,  J_WAIT_IN};
    endcase
  end

endmodule

/* src/bal_seq.sv */
// Step counter, microcode fetch and handshake control of the balance controller.
module bal_seq import bal_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output bal_ctl_t ctl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  uword_t            uw;
  logic              take;
  logic              hold;
  logic              out_load;

  bal_urom u_urom (
    .step (step),
    .uw   (uw)
  );

  // The input side is open only on the idle step.
  assign in_stall = (uw.jump != J_WAIT_IN);
  assign take     = in_valid && !in_stall;

  // The last step waits while an earlier result is still unclaimed.
  assign hold     = out_valid && out_stall;
  assign out_load = (uw.jump == J_END) && !hold;

  always_comb begin
    unique case (uw.jump)
      J_WAIT_IN: step_next = take ? step + 1'b1 : step;
      J_NEXT:    step_next = step + 1'b1;
      J_END:     step_next = hold ? step : '0;
      default:   step_next = '0;
    endcase
  end

  // Step counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ctl = '{uw: uw, take: take, out_load: out_load};

endmodule

/* src/bal_dpath.sv */
// Datapath: configuration, command state, shared multiplier, accumulator and output mix.
module bal_dpath import bal_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  bal_ctl_t                       ctl,
  input  logic                           cfg_write,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic signed [DATA_W-1:0]       pitch,
  input  logic signed [DATA_W-1:0]       pitch_rate,
  input  logic signed [DATA_W-1:0]       yaw_rate,
  input  logic signed [DATA_W-1:0]       wheel_count_left,
  input  logic signed [DATA_W-1:0]       wheel_count_right,
  input  logic                           go_forward,
  input  logic                           go_backward,
  input  logic                           steer_left,
  input  logic                           steer_right,
  input  logic                           avoid_mode,
  input  logic [DIST_W-1:0]              obstacle_distance,
  input  logic                           stop_request,
  output logic signed [OUT_W-1:0]        motor_left,
  output logic signed [OUT_W-1:0]        motor_right
);

  // Configuration registers.
  logic signed [GAIN_W-1:0]  angle_kp;
  logic signed [GAIN_W-1:0]  angle_kd;
  logic signed [GAIN_W-1:0]  speed_kp;
  logic signed [GAIN_W-1:0]  speed_ki;
  logic signed [GAIN_W-1:0]  turn_kp;
  logic signed [GAIN_W-1:0]  turn_kd_idle;
  logic signed [DATA_W-1:0]  balance_angle;
  logic [LIMIT_W-1:0]        drive_limit;

  // Controller state.
  logic signed [TSPD_W-1:0]     speed_cmd;
  logic signed [TURN_SPD_W-1:0] turn_cmd;
  logic signed [GAIN_W-1:0]     turn_damping;
  logic signed [FILT_W-1:0]     filt;
  logic signed [INTEG_W-1:0]    integ;

  // Per-tick operands captured at the input transfer.
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [DATA_W-1:0] prate_q;
  logic signed [DATA_W-1:0] yaw_q;
  logic signed [ERR_W-1:0]  err_q;
  logic                     stop_q;

  // Command update results.
  logic signed [TSPD_W-1:0]     target_next;
  logic signed [TURN_SPD_W-1:0] turn_cmd_next;
  logic signed [GAIN_W-1:0]     turn_damping_next;
  logic signed [TSPD_W:0]       tsum;
  logic signed [TURN_SPD_W:0]   rsum;

  // Arithmetic pipeline.
  logic signed [GAIN_W-1:0] opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  tq;
  logic signed [ACC_W-1:0]  acc;
  logic signed [UP_W-1:0]   up_q;
  logic signed [TURN_W-1:0] turn_q;
  logic signed [FILT_W:0]   isum;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [OUT_W-1:0]  lim;
  logic signed [ACC_W-1:0]  mix_left;
  logic signed [ACC_W-1:0]  mix_right;

  // Product divided by 2^16 or 2^23, rounded toward zero, or passed through unshifted.
  function automatic logic signed [PROD_W-1:0] prod_trunc(
    input logic signed [PROD_W-1:0] v,
    input shift_e                   sh
  );
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] r;
    unique case (sh)
      SH_16: begin
        bias = {{(PROD_W-16){1'b0}}, {16{v[PROD_W-1]}}};
        r    = (v + bias) >>> 16;
      end
      SH_23: begin
        bias = {{(PROD_W-23){1'b0}}, {23{v[PROD_W-1]}}};
        r    = (v + bias) >>> 23;
      end
      default: begin
        bias = '0;
        r    = v;
      end
    endcase
    return r;
  endfunction

  // Accumulator divided by 2^16, rounded toward zero.
  function automatic logic signed [ACC_W-1:0] acc_trunc16(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] bias;
    bias = {{(ACC_W-16){1'b0}}, {16{v[ACC_W-1]}}};
    return (v + bias) >>> 16;
  endfunction

  // Symmetric clamp of a mixed drive value.
  function automatic logic signed [OUT_W-1:0] drive_clamp(
    input logic signed [ACC_W-1:0] v,
    input logic signed [OUT_W-1:0] l
  );
    logic signed [OUT_W-1:0] r;
    if (v > ACC_W'(l)) begin
      r = l;
    end else if (v < -ACC_W'(l)) begin
      r = -l;
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_kp      <= GAIN_W'(RST_ANGLE_KP);
      angle_kd      <= GAIN_W'(RST_ANGLE_KD);
      speed_kp      <= GAIN_W'(RST_SPEED_KP);
      speed_ki      <= GAIN_W'(RST_SPEED_KI);
      turn_kp       <= GAIN_W'(RST_TURN_KP);
      turn_kd_idle  <= GAIN_W'(RST_TURN_KD_IDLE);
      balance_angle <= DATA_W'(RST_BALANCE_ANGLE);
      drive_limit   <= LIMIT_W'(RST_DRIVE_LIMIT);
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_ANGLE_KP:      angle_kp      <= cfg_data;
        REG_ANGLE_KD:      angle_kd      <= cfg_data;
        REG_SPEED_KP:      speed_kp      <= cfg_data;
        REG_SPEED_KI:      speed_ki      <= cfg_data;
        REG_TURN_KP:       turn_kp       <= cfg_data;
        REG_TURN_KD_IDLE:  turn_kd_idle  <= cfg_data;
        REG_BALANCE_ANGLE: balance_angle <= cfg_data[DATA_W-1:0];
        REG_DRIVE_LIMIT:   drive_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Motion command from the obstacle range or the buttons.
  always_comb begin
    tsum = (go_forward || go_backward) ? (TSPD_W+1)'(speed_cmd) : '0;
    tsum = tsum + (go_forward ? (TSPD_W+1)'(1) : '0) - (go_backward ? (TSPD_W+1)'(1) : '0);
    rsum = (steer_left || steer_right) ? (TURN_SPD_W+1)'(turn_cmd) : '0;
    rsum = rsum - (steer_left ? (TURN_SPD_W+1)'(TURN_STEP) : '0)
                + (steer_right ? (TURN_SPD_W+1)'(TURN_STEP) : '0);
    if (avoid_mode) begin
      turn_damping_next = turn_damping;
      if (obstacle_distance < DIST_W'(NEAR_CM)) begin
        target_next   = '0;
        turn_cmd_next = TURN_SPD_W'(TURN_MAX);
      end else begin
        target_next   = TSPD_W'(AVOID_SPEED);
        turn_cmd_next = '0;
      end
    end else begin
      if (tsum > (TSPD_W+1)'(SPEED_MAX)) begin
        target_next = TSPD_W'(SPEED_MAX);
      end else if (tsum < -(TSPD_W+1)'(SPEED_MAX)) begin
        target_next = -TSPD_W'(SPEED_MAX);
      end else begin
        target_next = TSPD_W'(tsum);
      end
      if (rsum > (TURN_SPD_W+1)'(TURN_MAX)) begin
        turn_cmd_next = TURN_SPD_W'(TURN_MAX);
      end else if (rsum < -(TURN_SPD_W+1)'(TURN_MAX)) begin
        turn_cmd_next = -TURN_SPD_W'(TURN_MAX);
      end else begin
        turn_cmd_next = TURN_SPD_W'(rsum);
      end
      turn_damping_next = (!steer_left && !steer_right) ? turn_kd_idle : '0;
    end
  end

  // Integral accumulation with clamp and stop clear.
  always_comb begin
    isum = (FILT_W+1)'(filt) + (FILT_W+1)'(integ);
    if (stop_q) begin
      integ_next = '0;
    end else if (isum > (FILT_W+1)'(INTEG_MAX)) begin
      integ_next = INTEG_W'(INTEG_MAX);
    end else if (isum < -(FILT_W+1)'(INTEG_MAX)) begin
      integ_next = -INTEG_W'(INTEG_MAX);
    end else begin
      integ_next = INTEG_W'(isum);
    end
  end

  // Controller state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_cmd    <= '0;
      turn_cmd     <= '0;
      turn_damping <= GAIN_W'(DAMP_RESET);
      filt         <= '0;
      integ        <= '0;
    end else begin
      if (ctl.take) begin
        speed_cmd    <= target_next;
        turn_cmd     <= turn_cmd_next;
        turn_damping <= turn_damping_next;
      end
      if (ctl.uw.wb == WB_FILT) begin
        filt <= FILT_W'(acc_trunc16(acc));
      end
      if (ctl.uw.wb == WB_INTEG) begin
        integ <= integ_next;
      end
    end
  end

  // Operand capture at the input transfer.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      diff_q  <= DIFF_W'(pitch) - DIFF_W'(balance_angle);
      prate_q <= pitch_rate;
      yaw_q   <= yaw_rate;
      err_q   <= ERR_W'(wheel_count_left) + ERR_W'(wheel_count_right)
               - ERR_W'(target_next);
      stop_q  <= stop_request;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctl.uw.a_sel)
      A_AKP:   opa = angle_kp;
      A_AKD:   opa = angle_kd;
      A_SKP:   opa = speed_kp;
      A_SKI:   opa = speed_ki;
      A_TKP:   opa = turn_kp;
      A_DAMP:  opa = turn_damping;
      A_FNEW:  opa = GAIN_W'(FILT_NEW);
      A_FOLD:  opa = GAIN_W'(FILT_OLD);
      default: opa = '0;
    endcase
    unique case (ctl.uw.b_sel)
      B_DIFF:    opb = OPB_W'(diff_q);
      B_PRATE:   opb = OPB_W'(prate_q);
      B_YAW:     opb = OPB_W'(yaw_q);
      B_ERR:     opb = OPB_W'(err_q);
      B_FILT:    opb = OPB_W'(filt);
      B_INTEG:   opb = OPB_W'(integ);
      B_TURNSPD: opb = OPB_W'(turn_cmd);
      B_ACC:     opb = OPB_W'(acc);
      default:   opb = '0;
    endcase
  end

  // Multiply, truncate and accumulate, one stage each.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(opa) * PROD_W'(opb);
    tq   <= ACC_W'(prod_trunc(prod, ctl.uw.shift));
    unique case (ctl.uw.acc_op)
      ACC_LOAD: acc <= tq;
      ACC_ADD:  acc <= acc + tq;
      ACC_SUB:  acc <= acc - tq;
      ACC_LDUP: acc <= ACC_W'(up_q);
      default:  acc <= acc;
    endcase
    if (ctl.uw.wb == WB_UP) begin
      up_q <= UP_W'(acc);
    end
    if (ctl.uw.wb == WB_TURN) begin
      turn_q <= TURN_W'(acc);
    end
  end

  // Drive mix: balance minus turn on the left, plus turn on the right.
  assign lim       = {1'b0, drive_limit};
  assign mix_left  = acc - ACC_W'(turn_q);
  assign mix_right = acc + ACC_W'(turn_q);

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      motor_left  <= drive_clamp(mix_left, lim);
      motor_right <= drive_clamp(mix_right, lim);
    end
  end

endmodule

/* src/balance_robot_cascaded_pid.sv */
// Top level of the cascaded upright, speed and turn controller for a two-wheel robot.
// One input transfer per control tick yields one pair of motor drives. The item is taken on
// the idle step, and 14 microcode steps then run all nine products through a single shared
// 26x30 multiplier, a truncation stage and one accumulator. The result waits in an output
// register, and the next item can be taken the cycle after the result is loaded; no new item
// is taken while a tick is in progress. When a result is still unclaimed as the next one
// completes, the last step holds until the output transfer. Configuration writes take effect
// by the next tick at the latest, and a write during a tick can change the tick in progress.
module balance_robot_cascaded_pid import bal_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [DATA_W-1:0]  pitch,
  input  logic signed [DATA_W-1:0]  pitch_rate,
  input  logic signed [DATA_W-1:0]  yaw_rate,
  input  logic signed [DATA_W-1:0]  wheel_count_left,
  input  logic signed [DATA_W-1:0]  wheel_count_right,
  input  logic                      go_forward,
  input  logic                      go_backward,
  input  logic                      steer_left,
  input  logic                      steer_right,
  input  logic                      avoid_mode,
  input  logic [DIST_W-1:0]         obstacle_distance,
  input  logic                      stop_request,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   motor_left,
  output logic signed [OUT_W-1:0]   motor_right
);

  bal_ctl_t ctl;

  // Sequencer with microcode ROM.
  bal_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Arithmetic datapath.
  bal_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pitch             (pitch),
    .pitch_rate        (pitch_rate),
    .yaw_rate          (yaw_rate),
    .wheel_count_left  (wheel_count_left),
    .wheel_count_right (wheel_count_right),
    .go_forward        (go_forward),
    .go_backward       (go_backward),
    .steer_left        (steer_left),
    .steer_right       (steer_right),
    .avoid_mode        (avoid_mode),
    .obstacle_distance (obstacle_distance),
    .stop_request      (stop_request),
    .motor_left        (motor_left),
    .motor_right       (motor_right)
  );

endmodule

/* src/bal_checker.sv */
// Port-level checker for the balance controller and its bind to the top level.
module bal_checker import bal_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OUT_W-1:0] motor_left,
  input logic signed [OUT_W-1:0] motor_right
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its drive values.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(motor_left) && $stable(motor_right))
    else $error("result changed while stalled");

  // After an input transfer the block is busy with that tick.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken again while a tick is in progress");

  // A new result only appears at the end of a tick in progress.
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a tick in progress");

endmodule

bind balance_robot_cascaded_pid bal_checker u_bal_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .motor_left  (motor_left),
  .motor_right (motor_right)
);
